@@ rtl/desc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_pkg
// Shared types, register codes, address map and identification ROM of the
// dual pulse controller.
// ----------------------------------------------------------------------------
package desc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] PWM_PERIOD_RST  = 16'd2000;
    localparam logic [7:0]  STOP_CMD_RST    = 8'd151;
    localparam logic [7:0]  LOW_LIMIT_RST   = 8'd111;
    localparam logic [7:0]  HIGH_LIMIT_RST  = 8'd191;
    localparam logic [7:0]  WDOG_RELOAD_RST = 8'd3;

    localparam logic [7:0]  VERSION_BYTE = 8'h01;
    localparam logic [8:0]  ADDR_CMD0    = 9'h000;
    localparam logic [8:0]  ADDR_CMD1    = 9'h001;
    localparam logic [8:0]  ADDR_WDOG    = 9'h002;
    localparam logic [8:0]  ADDR_EN0     = 9'h010;
    localparam logic [8:0]  ADDR_EN1     = 9'h011;
    localparam logic [8:0]  ADDR_VERSION = 9'h0C0;
    localparam logic [4:0]  ADDR_ROM_HI  = 5'h0F;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_READ  = 3'd2,
        CMD_WDOG  = 3'd3,
        CMD_PWM   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_PWM_PERIOD = 2'd0,
        CFG_STOP_CMD   = 2'd1,
        CFG_LOW_LIMIT  = 2'd2,
        CFG_HIGH_LIMIT = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        K_NONE,
        K_SETPTR,
        K_WRITE,
        K_READ,
        K_WDOG,
        K_PWM
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [8:0] addr;
        logic [7:0] data;
    } t_task;

    function automatic logic [7:0] id_rom(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'h0: v = 8'h50;
            4'h1: v = 8'h49;
            4'h2: v = 8'h43;
            4'h3: v = 8'h5F;
            4'h4: v = 8'h54;
            4'h5: v = 8'h48;
            4'h6: v = 8'h52;
            4'h7: v = 8'h55;
            4'h8: v = 8'h53;
            4'h9: v = 8'h54;
            4'hA: v = 8'h45;
            4'hB: v = 8'h52;
            4'hC: v = 8'h20;
            4'hD: v = 8'h76;
            4'hE: v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/desc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_if
// Request, result and register-write channels of the dual pulse controller.
// ----------------------------------------------------------------------------
interface desc_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] write_byte;
    modport source (output valid, output cmd, output write_byte, input ready);
    modport sink   (input valid, input cmd, input write_byte, output ready);
endinterface

interface desc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] rd_data;
    logic       esc_one_level;
    logic       esc_two_level;
    logic       led_level;
    modport source (output valid, output rd_data, output esc_one_level,
                    output esc_two_level, output led_level, input ready);
    modport sink   (input valid, input rd_data, input esc_one_level,
                    input esc_two_level, input led_level, output ready);
endinterface

interface desc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/dual_esc_pulse_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_esc_pulse_controller_top
// Two-channel pulse generator behind a byte-bus register map with watchdog.
// ----------------------------------------------------------------------------
// Every accepted request (transfer start, byte write, byte read, watchdog
// tick or PWM tick) returns exactly one result, in order. One request is
// taken per clock cycle at a sustained rate while results are taken. Each
// request enters the queue and, once popped while the result register is free
// or being emptied, has its result registered. The decode side updates the
// register pointer and byte count, a small queue decouples it from the
// execution side, which updates the register map, watchdog and pulse counters
// and holds the result register. Register writes take effect at once; the user
// makes them while no request is in flight; the block does not enforce it.
module dual_esc_pulse_controller_top #(
    parameter int QUEUE_DEPTH = desc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    desc_item_if.sink     i_item,
    desc_cfg_if.sink      i_cfg,
    desc_result_if.source o_result
);

    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_valid;
    desc_pkg::t_task w_front_task;
    desc_pkg::t_task w_back_task;

    desc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_task  (w_front_task)
    );

    desc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_task  (w_front_task),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_task  (w_back_task)
    );

    desc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_task   (w_back_task),
        .o_pop    (w_pop),
        .i_cfg    (i_cfg),
        .o_result (o_result)
    );

endmodule

@@ rtl/desc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_front
// Accepts bus events, tracks register pointer and byte count, and turns each
// request into a decoded task for the execution side.
// ----------------------------------------------------------------------------
module desc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    desc_item_if.sink          i_item,
    input  logic               i_full,
    output logic               o_push,
    output desc_pkg::t_task    o_task
);

    logic [7:0] r_pointer;
    logic [7:0] r_count;
    logic [7:0] n_pointer;
    logic [7:0] n_count;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        n_pointer   = r_pointer;
        n_count     = r_count;
        o_task.kind = desc_pkg::K_NONE;
        o_task.addr = {1'b0, r_pointer} + {1'b0, r_count};
        o_task.data = i_item.write_byte;
        case (i_item.cmd)
            desc_pkg::CMD_START: begin
                n_count = 8'd0;
            end
            desc_pkg::CMD_WRITE: begin
                if (r_count == 8'd0) begin
                    n_pointer   = i_item.write_byte;
                    o_task.kind = desc_pkg::K_SETPTR;
                end else begin
                    o_task.kind = desc_pkg::K_WRITE;
                    o_task.addr = {1'b0, r_pointer} + {1'b0, r_count} - 9'd1;
                end
                n_count = r_count + 8'd1;
            end
            desc_pkg::CMD_READ: begin
                o_task.kind = desc_pkg::K_READ;
                n_count     = r_count + 8'd1;
            end
            desc_pkg::CMD_WDOG: o_task.kind = desc_pkg::K_WDOG;
            desc_pkg::CMD_PWM:  o_task.kind = desc_pkg::K_PWM;
            default:            o_task.kind = desc_pkg::K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer <= 8'd0;
            r_count   <= 8'd0;
        end else if (o_push) begin
            r_pointer <= n_pointer;
            r_count   <= n_count;
        end
    end

endmodule

@@ rtl/desc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_queue
// Small task queue between the decode side and the execution side.
// ----------------------------------------------------------------------------
module desc_queue #(
    parameter int DEPTH = desc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  desc_pkg::t_task i_task,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output desc_pkg::t_task o_task
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_pkg::t_task r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_task  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count exceeds depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count lost a request");
`endif

endmodule

@@ rtl/desc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// desc_back
// Executes decoded tasks on the register map, watchdog and pulse counters,
// and holds the result register.
// ----------------------------------------------------------------------------
module desc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  desc_pkg::t_task i_task,
    output logic            o_pop,
    desc_cfg_if.sink        i_cfg,
    desc_result_if.source   o_result
);

    logic [15:0] r_pwm_period;
    logic [7:0]  r_stop_cmd;
    logic [7:0]  r_low_limit;
    logic [7:0]  r_high_limit;

    logic [7:0]  r_cmd       [2];
    logic [7:0]  r_pulse_rem [2];
    logic        r_enable    [2];
    logic        r_level     [2];
    logic [15:0] r_period_rem;
    logic [7:0]  r_wd_reload;
    logic [7:0]  r_wd_rem;

    logic [7:0]  n_cmd       [2];
    logic [7:0]  n_pulse_rem [2];
    logic        n_enable    [2];
    logic        n_level     [2];
    logic [15:0] n_period_rem;
    logic [7:0]  n_wd_reload;
    logic [7:0]  n_wd_rem;
    logic [7:0]  n_rd;
    logic        n_led;
    logic        w_ok;

    logic        r_out_valid;
    logic [7:0]  r_rd;
    logic        r_out_level [2];
    logic        r_led;

    assign o_pop = i_valid && (!r_out_valid || o_result.ready);
    assign w_ok  = (i_task.data > r_low_limit) && (i_task.data < r_high_limit);

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cmd        = r_cmd;
        n_pulse_rem  = r_pulse_rem;
        n_enable     = r_enable;
        n_level      = r_level;
        n_period_rem = r_period_rem;
        n_wd_reload  = r_wd_reload;
        n_wd_rem     = r_wd_rem;
        n_rd         = 8'd0;
        case (i_task.kind)
            desc_pkg::K_SETPTR: begin
                n_wd_rem = r_wd_reload;
            end
            desc_pkg::K_WRITE: begin
                case (i_task.addr)
                    desc_pkg::ADDR_CMD0: if (w_ok) n_cmd[0] = i_task.data;
                    desc_pkg::ADDR_CMD1: if (w_ok) n_cmd[1] = i_task.data;
                    desc_pkg::ADDR_WDOG: n_wd_reload = i_task.data;
                    desc_pkg::ADDR_EN0:  n_enable[0] = (i_task.data == 8'd1);
                    desc_pkg::ADDR_EN1:  n_enable[1] = (i_task.data == 8'd1);
                    default:             n_wd_reload = r_wd_reload;
                endcase
                n_wd_rem = n_wd_reload;
            end
            desc_pkg::K_READ: begin
                case (i_task.addr)
                    desc_pkg::ADDR_CMD0:    n_rd = r_cmd[0];
                    desc_pkg::ADDR_CMD1:    n_rd = r_cmd[1];
                    desc_pkg::ADDR_WDOG:    n_rd = r_wd_reload;
                    desc_pkg::ADDR_EN0:     n_rd = {7'd0, r_enable[0]};
                    desc_pkg::ADDR_EN1:     n_rd = {7'd0, r_enable[1]};
                    desc_pkg::ADDR_VERSION: n_rd = desc_pkg::VERSION_BYTE;
                    default: begin
                        if (i_task.addr[8:4] == desc_pkg::ADDR_ROM_HI) begin
                            n_rd = desc_pkg::id_rom(i_task.addr[3:0]);
                        end
                    end
                endcase
            end
            desc_pkg::K_WDOG: begin
                if (r_wd_rem != 8'd0) begin
                    n_wd_rem = r_wd_rem - 8'd1;
                end else begin
                    n_cmd[0] = r_stop_cmd;
                    n_cmd[1] = r_stop_cmd;
                end
            end
            desc_pkg::K_PWM: begin
                if (r_period_rem == 16'd0) begin
                    n_period_rem = r_pwm_period;
                    for (int c = 0; c < 2; c++) begin
                        if (r_enable[c]) n_level[c] = 1'b1;
                        n_pulse_rem[c] = r_cmd[c];
                    end
                end else begin
                    n_period_rem = r_period_rem - 16'd1;
                    for (int c = 0; c < 2; c++) begin
                        if (r_pulse_rem[c] == 8'd0) n_level[c] = 1'b0;
                        else n_pulse_rem[c] = r_pulse_rem[c] - 8'd1;
                    end
                end
            end
            default: n_rd = 8'd0;
        endcase
        n_led = (n_cmd[0] != r_stop_cmd) || (n_cmd[1] != r_stop_cmd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= desc_pkg::PWM_PERIOD_RST;
            r_stop_cmd   <= desc_pkg::STOP_CMD_RST;
            r_low_limit  <= desc_pkg::LOW_LIMIT_RST;
            r_high_limit <= desc_pkg::HIGH_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                desc_pkg::CFG_PWM_PERIOD: r_pwm_period <= i_cfg.data;
                desc_pkg::CFG_STOP_CMD:   r_stop_cmd   <= i_cfg.data[7:0];
                desc_pkg::CFG_LOW_LIMIT:  r_low_limit  <= i_cfg.data[7:0];
                desc_pkg::CFG_HIGH_LIMIT: r_high_limit <= i_cfg.data[7:0];
                default:                  r_pwm_period <= r_pwm_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_cmd[c]       <= desc_pkg::STOP_CMD_RST;
                r_pulse_rem[c] <= 8'd0;
                r_enable[c]    <= 1'b1;
                r_level[c]     <= 1'b0;
            end
            r_period_rem <= desc_pkg::PWM_PERIOD_RST;
            r_wd_reload  <= desc_pkg::WDOG_RELOAD_RST;
            r_wd_rem     <= desc_pkg::WDOG_RELOAD_RST;
        end else if (o_pop) begin
            r_cmd        <= n_cmd;
            r_pulse_rem  <= n_pulse_rem;
            r_enable     <= n_enable;
            r_level      <= n_level;
            r_period_rem <= n_period_rem;
            r_wd_reload  <= n_wd_reload;
            r_wd_rem     <= n_wd_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd        <= n_rd;
            r_out_level <= n_level;
            r_led       <= n_led;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.rd_data       = r_rd;
    assign o_result.esc_one_level = r_out_level[0];
    assign o_result.esc_two_level = r_out_level[1];
    assign o_result.led_level     = r_led;

`ifndef SYNTHESIS
    a_wdog_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_task.kind == desc_pkg::K_WDOG && r_wd_rem == 8'd0)
        |=> (r_cmd[0] == $past(r_stop_cmd) && r_cmd[1] == $past(r_stop_cmd)))
        else $error("watchdog expiry did not force stop");
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_task.kind != desc_pkg::K_READ) |=> r_rd == 8'd0)
        else $error("nonzero read data on a non-read request");
    a_led_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_led == ((r_cmd[0] != r_stop_cmd) || (r_cmd[1] != r_stop_cmd)))
        else $error("led disagrees with pulse commands");
`endif

endmodule
